FILE: design/ols_pkg.sv
// ols_pkg: shared types, request and status codes for the ordered list store.
// Used by ols_ctrl, ols_datapath and ordered_list_store_core.
`timescale 1ns / 1ps
`default_nettype none
package ols_pkg;

	localparam int DEPTH = 16;
	localparam int IDX_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam int POS_W = 4;
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	typedef logic [IDX_W-1:0] idx_t;
	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [CMP_W-1:0] cmp_t;

	localparam logic [2:0] REQ_PUSH_FRONT = 3'd0;
	localparam logic [2:0] REQ_PUSH_BACK  = 3'd1;
	localparam logic [2:0] REQ_REMOVE     = 3'd2;
	localparam logic [2:0] REQ_READ       = 3'd3;
	localparam logic [2:0] REQ_CLEAR      = 3'd4;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_RANGE = 2'd2;

	typedef struct packed {
		logic [2:0]        req_type;
		logic signed [31:0] value;
		logic [POS_W-1:0]  position;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic [1:0]         status;
		logic [4:0]         count;
		logic signed [31:0] last_value;
		logic               last_valid;
	} rsp_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DISPATCH,
		S_SHIFT_UP,
		S_UP_TAIL,
		S_FRONT,
		S_SHIFT_DN,
		S_DN_TAIL,
		S_LAST_RD,
		S_LAST_LD,
		S_FINISH
	} ctl_state_t;

	typedef enum logic [4:0] {
		OP_NOP,
		OP_CAPTURE,
		OP_FLAG_FULL,
		OP_FLAG_RANGE,
		OP_IGNORE,
		OP_CLEAR,
		OP_PUSH_BACK,
		OP_PUSH_FRONT,
		OP_START_UP,
		OP_START_DN,
		OP_DROP_TAIL,
		OP_READ_POS,
		OP_SHIFT_UP,
		OP_SHIFT_DN,
		OP_FLUSH_UP,
		OP_FLUSH_DN,
		OP_READ_LAST,
		OP_LOAD_LAST,
		OP_RESPOND
	} dp_op_t;

	typedef struct packed {
		logic [2:0] req_type;
		logic       full;
		logic       empty;
		logic       pos_ok;
		logic       pos_last;
		logic       many;
		logic       ptr_zero;
		logic       ptr_end;
		logic       rsp_busy;
	} dp_stat_t;

endpackage
`default_nettype wire

FILE: design/ols_datapath.sv
// ols_datapath: element memory, count, last-element and response registers.
// Executes one ols_pkg::dp_op_t per cycle; types from ols_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ols_datapath (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire ols_pkg::req_t     req,
	input  wire ols_pkg::dp_op_t   op,
	input  wire logic              rsp_stall,
	output ols_pkg::dp_stat_t      stat,
	output logic                   rsp_valid,
	output ols_pkg::rsp_t          rsp
);

	logic [31:0]         mem_q [ols_pkg::DEPTH];
	logic [31:0]         rdata_q;
	logic [31:0]         value_q;
	logic [31:0]         last_q;
	logic [2:0]          type_q;
	logic [ols_pkg::POS_W-1:0] pos_q;
	logic [1:0]          status_q;
	ols_pkg::cnt_t       count_q;
	ols_pkg::idx_t       ptr_q;
	ols_pkg::idx_t       waddr_q;
	logic                wpend_q;
	logic                rsp_valid_q;
	ols_pkg::rsp_t       rsp_q;

	logic                we;
	ols_pkg::idx_t       waddr;
	logic [31:0]         wdata;
	logic                re;
	ols_pkg::idx_t       raddr;
	ols_pkg::cnt_t       count_m1;
	logic                count_nz;

	assign count_m1 = count_q - ols_pkg::cnt_t'(1);
	assign count_nz = (count_q != '0);

	always_comb begin
		stat.req_type = type_q;
		stat.full     = (count_q == ols_pkg::cnt_t'(ols_pkg::DEPTH));
		stat.empty    = !count_nz;
		stat.pos_ok   = (ols_pkg::cmp_t'(pos_q) < ols_pkg::cmp_t'(count_q));
		stat.pos_last = (ols_pkg::cmp_t'(pos_q) == ols_pkg::cmp_t'(count_m1));
		stat.many     = (count_q > ols_pkg::cnt_t'(1));
		stat.ptr_zero = (ptr_q == '0);
		stat.ptr_end  = (ols_pkg::cnt_t'(ptr_q) == count_m1);
		stat.rsp_busy = rsp_valid_q && rsp_stall;
	end

	always_comb begin
		we    = 1'b0;
		waddr = waddr_q;
		wdata = rdata_q;
		re    = 1'b0;
		raddr = ptr_q;
		unique case (op)
			ols_pkg::OP_PUSH_BACK: begin
				we    = 1'b1;
				waddr = ols_pkg::idx_t'(count_q);
				wdata = value_q;
			end
			ols_pkg::OP_PUSH_FRONT: begin
				we    = 1'b1;
				waddr = '0;
				wdata = value_q;
			end
			ols_pkg::OP_SHIFT_UP, ols_pkg::OP_SHIFT_DN: begin
				we = wpend_q;
				re = 1'b1;
			end
			ols_pkg::OP_FLUSH_UP, ols_pkg::OP_FLUSH_DN: begin
				we = wpend_q;
			end
			ols_pkg::OP_READ_POS: begin
				re    = 1'b1;
				raddr = ols_pkg::idx_t'(pos_q);
			end
			ols_pkg::OP_READ_LAST: begin
				re    = 1'b1;
				raddr = ols_pkg::idx_t'(count_m1);
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q     <= '0;
			wpend_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (op == ols_pkg::OP_RESPOND) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			unique case (op)
				ols_pkg::OP_CLEAR:      count_q <= '0;
				ols_pkg::OP_PUSH_BACK,
				ols_pkg::OP_PUSH_FRONT: count_q <= count_q + ols_pkg::cnt_t'(1);
				ols_pkg::OP_DROP_TAIL,
				ols_pkg::OP_FLUSH_DN:   count_q <= count_m1;
				ols_pkg::OP_START_UP,
				ols_pkg::OP_START_DN,
				ols_pkg::OP_FLUSH_UP:   wpend_q <= 1'b0;
				ols_pkg::OP_SHIFT_UP,
				ols_pkg::OP_SHIFT_DN:   wpend_q <= 1'b1;
				default: begin
				end
			endcase
			if (op == ols_pkg::OP_FLUSH_DN) begin
				wpend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		unique case (op)
			ols_pkg::OP_CAPTURE: begin
				type_q  <= req.req_type;
				value_q <= req.value;
				pos_q   <= req.position;
			end
			ols_pkg::OP_FLAG_FULL:  status_q <= ols_pkg::ST_FULL;
			ols_pkg::OP_FLAG_RANGE: status_q <= ols_pkg::ST_RANGE;
			ols_pkg::OP_IGNORE,
			ols_pkg::OP_CLEAR,
			ols_pkg::OP_DROP_TAIL,
			ols_pkg::OP_READ_POS:   status_q <= ols_pkg::ST_OK;
			ols_pkg::OP_PUSH_BACK: begin
				status_q <= ols_pkg::ST_OK;
				last_q   <= value_q;
			end
			ols_pkg::OP_PUSH_FRONT: begin
				status_q <= ols_pkg::ST_OK;
				if (!count_nz) begin
					last_q <= value_q;
				end
			end
			ols_pkg::OP_START_UP: begin
				status_q <= ols_pkg::ST_OK;
				ptr_q    <= ols_pkg::idx_t'(count_m1);
			end
			ols_pkg::OP_START_DN: begin
				status_q <= ols_pkg::ST_OK;
				ptr_q    <= ols_pkg::idx_t'(pos_q) + ols_pkg::idx_t'(1);
			end
			ols_pkg::OP_SHIFT_UP: begin
				waddr_q <= ptr_q + ols_pkg::idx_t'(1);
				if (!stat.ptr_zero) begin
					ptr_q <= ptr_q - ols_pkg::idx_t'(1);
				end
			end
			ols_pkg::OP_SHIFT_DN: begin
				waddr_q <= ptr_q - ols_pkg::idx_t'(1);
				if (!stat.ptr_end) begin
					ptr_q <= ptr_q + ols_pkg::idx_t'(1);
				end
			end
			ols_pkg::OP_LOAD_LAST:  last_q <= rdata_q;
			ols_pkg::OP_RESPOND: begin
				rsp_q.read_value <= (type_q == ols_pkg::REQ_READ && status_q == ols_pkg::ST_OK)
					? rdata_q : 32'sd0;
				rsp_q.status     <= status_q;
				rsp_q.count      <= 5'(count_q);
				rsp_q.last_value <= count_nz ? last_q : 32'sd0;
				rsp_q.last_valid <= count_nz;
			end
			default: begin
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

FILE: design/ols_ctrl.sv
// ols_ctrl: request sequencer for the ordered list store.
// Issues one datapath op per cycle from datapath status; types from ols_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ols_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_stall,
	input  wire ols_pkg::dp_stat_t stat,
	output ols_pkg::dp_op_t        op
);

	ols_pkg::ctl_state_t state_q;
	ols_pkg::ctl_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ols_pkg::S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		op        = ols_pkg::OP_NOP;
		req_stall = 1'b1;
		unique case (state_q)
			ols_pkg::S_IDLE: begin
				req_stall = 1'b0;
				if (req_valid) begin
					op      = ols_pkg::OP_CAPTURE;
					state_d = ols_pkg::S_DISPATCH;
				end
			end
			ols_pkg::S_DISPATCH: begin
				state_d = ols_pkg::S_FINISH;
				unique case (stat.req_type)
					ols_pkg::REQ_PUSH_FRONT: begin
						if (stat.full) begin
							op = ols_pkg::OP_FLAG_FULL;
						end else if (stat.empty) begin
							op = ols_pkg::OP_PUSH_FRONT;
						end else begin
							op      = ols_pkg::OP_START_UP;
							state_d = ols_pkg::S_SHIFT_UP;
						end
					end
					ols_pkg::REQ_PUSH_BACK: begin
						op = stat.full ? ols_pkg::OP_FLAG_FULL : ols_pkg::OP_PUSH_BACK;
					end
					ols_pkg::REQ_REMOVE: begin
						if (!stat.pos_ok) begin
							op = ols_pkg::OP_FLAG_RANGE;
						end else if (stat.pos_last) begin
							op = ols_pkg::OP_DROP_TAIL;
							if (stat.many) begin
								state_d = ols_pkg::S_LAST_RD;
							end
						end else begin
							op      = ols_pkg::OP_START_DN;
							state_d = ols_pkg::S_SHIFT_DN;
						end
					end
					ols_pkg::REQ_READ: begin
						op = stat.pos_ok ? ols_pkg::OP_READ_POS : ols_pkg::OP_FLAG_RANGE;
					end
					ols_pkg::REQ_CLEAR: begin
						op = ols_pkg::OP_CLEAR;
					end
					default: begin
						op = ols_pkg::OP_IGNORE;
					end
				endcase
			end
			ols_pkg::S_SHIFT_UP: begin
				op = ols_pkg::OP_SHIFT_UP;
				if (stat.ptr_zero) begin
					state_d = ols_pkg::S_UP_TAIL;
				end
			end
			ols_pkg::S_UP_TAIL: begin
				op      = ols_pkg::OP_FLUSH_UP;
				state_d = ols_pkg::S_FRONT;
			end
			ols_pkg::S_FRONT: begin
				op      = ols_pkg::OP_PUSH_FRONT;
				state_d = ols_pkg::S_FINISH;
			end
			ols_pkg::S_SHIFT_DN: begin
				op = ols_pkg::OP_SHIFT_DN;
				if (stat.ptr_end) begin
					state_d = ols_pkg::S_DN_TAIL;
				end
			end
			ols_pkg::S_DN_TAIL: begin
				op      = ols_pkg::OP_FLUSH_DN;
				state_d = ols_pkg::S_FINISH;
			end
			ols_pkg::S_LAST_RD: begin
				op      = ols_pkg::OP_READ_LAST;
				state_d = ols_pkg::S_LAST_LD;
			end
			ols_pkg::S_LAST_LD: begin
				op      = ols_pkg::OP_LOAD_LAST;
				state_d = ols_pkg::S_FINISH;
			end
			ols_pkg::S_FINISH: begin
				if (!stat.rsp_busy) begin
					op      = ols_pkg::OP_RESPOND;
					state_d = ols_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = ols_pkg::S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

FILE: design/ordered_list_store_core.sv
// Ordered list store, up to DEPTH signed 32-bit elements in a single-port-write memory.
// Push front into a non-empty list shifts every element up one slot before writing slot 0;
// remove shifts the elements above position down, or, when removing the last of several, reloads the new last.
// Throughput: one request at a time, set by the one-element-per-cycle shift through the
// memory port. Reset empties the list; no clearing pass.
// Depends on ols_pkg, ols_ctrl and ols_datapath.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_store_core (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_stall,
	input  wire ols_pkg::req_t  req,
	output logic                rsp_valid,
	input  wire logic           rsp_stall,
	output ols_pkg::rsp_t       rsp
);

	ols_pkg::dp_op_t   op;
	ols_pkg::dp_stat_t stat;

	ols_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.stat      (stat),
		.op        (op)
	);

	ols_datapath u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.op        (op),
		.rsp_stall (rsp_stall),
		.stat      (stat),
		.rsp_valid (rsp_valid),
		.rsp       (rsp)
	);

endmodule
`default_nettype wire
